// ===== rtl/core/u8u16_pkg.sv =====
// Shared constants and types for the UTF-8 to UTF-16 transcoder.
`timescale 1ns / 1ps

package u8u16_pkg;

    // Output buffer sizing
    localparam int FifoDepth = 8;
    localparam int PtrW      = $clog2(FifoDepth);
    localparam int CntW      = PtrW + 1;
    localparam int MaxRes    = 4;
    localparam int ResCntW   = $clog2(MaxRes + 1);

    // Fixed code points and limits
    localparam logic [15:0] REPL_UNIT   = 16'hFFFD;
    localparam logic [20:0] MAX_POINT   = 21'h10FFFF;
    localparam logic [20:0] SUPP_BASE   = 21'h010000;
    localparam logic [20:0] MIN_TWO     = 21'h000080;
    localparam logic [20:0] MIN_THREE   = 21'h000800;
    localparam logic [20:0] SURR_LOW    = 21'h00D800;
    localparam logic [20:0] SURR_HIGH   = 21'h00DFFF;
    localparam logic [5:0]  HI_SURR_TAG = 6'b110110;   // 0xD800 >> 10
    localparam logic [5:0]  LO_SURR_TAG = 6'b110111;   // 0xDC00 >> 10

    // Continuation bytes required by an open sequence
    localparam logic [1:0] SEQ_NONE  = 2'd0;
    localparam logic [1:0] SEQ_TWO   = 2'd1;
    localparam logic [1:0] SEQ_THREE = 2'd2;
    localparam logic [1:0] SEQ_FOUR  = 2'd3;

    // One buffered result word
    typedef struct packed {
        logic [15:0] code_unit;
        logic        run_last;
        logic        replaced;
        logic        final_unit;
    } unit_word_t;

endpackage

// ===== rtl/core/utf8_to_utf16_transcoder.sv =====
// UTF-8 to UTF-16 transcoder: byte decoder feeding an eight-word output buffer.
// Each unit is written to the buffer registers; the master side reads the head word.
// Throughput: one byte per cycle while the buffer holds four or fewer words;
// one unit leaves per cycle while m_tready is high; multi-unit bytes drain at that rate.
// The buffer admits a byte only when four words are free (worst case for one byte).
// Reset empties the buffer and closes any open sequence at once.
`timescale 1ns / 1ps

module utf8_to_utf16_transcoder
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,     // [7:0] byte_in
    input  logic        s_tlast,     // stream_end
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,     // [15:0] code_unit
    output logic        m_tlast,     // run_last
    output logic [1:0]  m_tuser      // [0] replaced, [1] final_unit
);
    import u8u16_pkg::*;

    // Decoder state
    logic [20:0] point_reg, point_next;
    logic [1:0]  seq_len_reg, seq_len_next;
    logic [1:0]  taken_reg, taken_next;

    // Output buffer
    unit_word_t  fifo_mem [FifoDepth];
    logic [PtrW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CntW-1:0] count_reg;

    // Per-byte results
    logic [15:0]        res_unit [MaxRes];
    logic [MaxRes-1:0]  res_repl;
    logic [ResCntW-1:0] res_n;

    logic        accept, pop, cont, do_fresh, bad;
    logic [1:0]  taken_inc;
    logic [20:0] cp, supp;

    assign accept   = s_tvalid && s_tready;
    assign pop      = m_tvalid && m_tready;
    assign s_tready = (count_reg <= CntW'(FifoDepth - MaxRes));
    assign cont     = (s_tdata[7:6] == 2'b10);

    // Decode one byte against the open sequence
    always_comb
    begin
        point_next   = point_reg;
        seq_len_next = seq_len_reg;
        taken_next   = taken_reg;
        res_n        = '0;
        res_repl     = '0;
        for (int k = 0; k < MaxRes; k++)
        begin
            res_unit[k] = '0;
        end
        do_fresh  = 1'b0;
        bad       = 1'b0;
        taken_inc = taken_reg + 2'd1;
        cp        = {point_reg[14:0], s_tdata[5:0]};
        supp      = cp - SUPP_BASE;

        if (seq_len_reg != SEQ_NONE)
        begin
            if (cont)
            begin
                point_next = cp;
                taken_next = taken_inc;
                if (taken_inc == seq_len_reg)
                begin
                    case (seq_len_reg)
                        SEQ_TWO:   bad = (cp < MIN_TWO);
                        SEQ_THREE: bad = (cp < MIN_THREE) || (cp >= SURR_LOW && cp <= SURR_HIGH);
                        default:   bad = (cp < SUPP_BASE) || (cp > MAX_POINT);
                    endcase
                    if (bad)
                    begin
                        res_unit[0] = REPL_UNIT;
                        res_repl[0] = 1'b1;
                        res_n       = ResCntW'(1);
                    end
                    else if (cp[20:16] == 5'd0)
                    begin
                        res_unit[0] = cp[15:0];
                        res_n       = ResCntW'(1);
                    end
                    else
                    begin
                        res_unit[0] = {HI_SURR_TAG, supp[19:10]};
                        res_unit[1] = {LO_SURR_TAG, supp[9:0]};
                        res_n       = ResCntW'(2);
                    end
                    point_next   = '0;
                    seq_len_next = SEQ_NONE;
                    taken_next   = '0;
                end
            end
            else
            begin
                // broken sequence: one replacement for the lead and each byte taken
                for (int k = 0; k < MaxRes - 1; k++)
                begin
                    if (2'(k) <= taken_reg)
                    begin
                        res_unit[k] = REPL_UNIT;
                        res_repl[k] = 1'b1;
                    end
                end
                res_n        = ResCntW'(taken_reg) + ResCntW'(1);
                point_next   = '0;
                seq_len_next = SEQ_NONE;
                taken_next   = '0;
                do_fresh     = 1'b1;
            end
        end
        else
        begin
            do_fresh = 1'b1;
        end

        // Byte taken outside any sequence
        if (do_fresh)
        begin
            if (!s_tdata[7])
            begin
                res_unit[res_n[1:0]] = {8'd0, s_tdata};
                res_n                = res_n + ResCntW'(1);
            end
            else if (s_tdata[7:5] == 3'b110)
            begin
                point_next   = {16'd0, s_tdata[4:0]};
                seq_len_next = SEQ_TWO;
                taken_next   = '0;
            end
            else if (s_tdata[7:4] == 4'b1110)
            begin
                point_next   = {17'd0, s_tdata[3:0]};
                seq_len_next = SEQ_THREE;
                taken_next   = '0;
            end
            else if (s_tdata[7:3] == 5'b11110)
            begin
                point_next   = {18'd0, s_tdata[2:0]};
                seq_len_next = SEQ_FOUR;
                taken_next   = '0;
            end
            else
            begin
                // stray continuation or invalid lead
                res_unit[res_n[1:0]] = REPL_UNIT;
                res_repl[res_n[1:0]] = 1'b1;
                res_n                = res_n + ResCntW'(1);
            end
        end

        // Sequence cut short by end of stream
        if (s_tlast && seq_len_next != SEQ_NONE)
        begin
            res_unit[res_n[1:0]] = REPL_UNIT;
            res_repl[res_n[1:0]] = 1'b1;
            res_n                = res_n + ResCntW'(1);
            point_next           = '0;
            seq_len_next         = SEQ_NONE;
            taken_next           = '0;
        end
    end

    // Decoder state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            point_reg   <= '0;
            seq_len_reg <= SEQ_NONE;
            taken_reg   <= '0;
        end
        else if (accept)
        begin
            point_reg   <= point_next;
            seq_len_reg <= seq_len_next;
            taken_reg   <= taken_next;
        end
    end

    // Buffer write of up to four words per byte
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            for (int k = 0; k < MaxRes; k++)
            begin
                if (ResCntW'(k) < res_n)
                begin
                    fifo_mem[wr_ptr_reg + PtrW'(k)] <= '{
                        code_unit:  res_unit[k],
                        run_last:   (ResCntW'(k + 1) == res_n),
                        replaced:   res_repl[k],
                        final_unit: s_tlast && (ResCntW'(k + 1) == res_n)
                    };
                end
            end
        end
    end

    // Buffer pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (accept)
            begin
                wr_ptr_reg <= wr_ptr_reg + PtrW'(res_n);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PtrW'(1);
            end
            count_reg <= count_reg + (accept ? CntW'(res_n) : CntW'(0)) - CntW'(pop);
        end
    end

    // Master side reads the head word
    assign m_tvalid   = (count_reg != '0);
    assign m_tdata    = fifo_mem[rd_ptr_reg].code_unit;
    assign m_tlast    = fifo_mem[rd_ptr_reg].run_last;
    assign m_tuser[0] = fifo_mem[rd_ptr_reg].replaced;
    assign m_tuser[1] = fifo_mem[rd_ptr_reg].final_unit;

    // Checks
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CntW'(FifoDepth))
        else $error("output buffer overfilled");

    a_taken_below_len: assert property (@(posedge clk) disable iff (!rst_n)
        (seq_len_reg == SEQ_NONE) || (taken_reg < seq_len_reg))
        else $error("continuation count reached sequence length");

    a_end_closes: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && s_tlast) |=> (seq_len_reg == SEQ_NONE))
        else $error("sequence left open after end of stream");

    a_repl_value: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[0]) |-> (m_tdata == REPL_UNIT))
        else $error("replaced word is not the replacement character");

    a_final_has_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[1]) |-> m_tlast)
        else $error("final word not marked as last of its byte");

endmodule
